/* hw/rtl/onpf_pkg.sv */
package onpf_pkg;

	// fixed field widths
	localparam int unsigned PATH_W = 48;
	localparam int unsigned DEPTH_W = 5;
	localparam int unsigned GROUP_W = 3;
	localparam int unsigned KIND_W = 5;
	localparam int unsigned KIND_COUNT = 26;
	localparam int unsigned AXES = 3;
	localparam int unsigned MAX_DEPTH_DEF = 16;

	// axis of a child index bit: x is bit 0, y is bit 1, z is bit 2
	localparam int unsigned AX_X = 0;
	localparam int unsigned AX_Y = 1;
	localparam int unsigned AX_Z = 2;

	// neighborhood group bits
	localparam logic [GROUP_W-1:0] GRP_FACE = 3'b001;
	localparam logic [GROUP_W-1:0] GRP_EDGE = 3'b010;
	localparam logic [GROUP_W-1:0] GRP_VERTEX = 3'b100;

	// direction set codes, in emit order
	localparam logic [KIND_W-1:0] K_D = 5'd0;
	localparam logic [KIND_W-1:0] K_U = 5'd1;
	localparam logic [KIND_W-1:0] K_R = 5'd2;
	localparam logic [KIND_W-1:0] K_L = 5'd3;
	localparam logic [KIND_W-1:0] K_B = 5'd4;
	localparam logic [KIND_W-1:0] K_F = 5'd5;
	localparam logic [KIND_W-1:0] K_DR = 5'd6;
	localparam logic [KIND_W-1:0] K_DL = 5'd7;
	localparam logic [KIND_W-1:0] K_DF = 5'd8;
	localparam logic [KIND_W-1:0] K_DB = 5'd9;
	localparam logic [KIND_W-1:0] K_UR = 5'd10;
	localparam logic [KIND_W-1:0] K_UL = 5'd11;
	localparam logic [KIND_W-1:0] K_UF = 5'd12;
	localparam logic [KIND_W-1:0] K_UB = 5'd13;
	localparam logic [KIND_W-1:0] K_BR = 5'd14;
	localparam logic [KIND_W-1:0] K_BL = 5'd15;
	localparam logic [KIND_W-1:0] K_FR = 5'd16;
	localparam logic [KIND_W-1:0] K_FL = 5'd17;
	localparam logic [KIND_W-1:0] K_DRF = 5'd18;
	localparam logic [KIND_W-1:0] K_DRB = 5'd19;
	localparam logic [KIND_W-1:0] K_DLF = 5'd20;
	localparam logic [KIND_W-1:0] K_DLB = 5'd21;
	localparam logic [KIND_W-1:0] K_URF = 5'd22;
	localparam logic [KIND_W-1:0] K_URB = 5'd23;
	localparam logic [KIND_W-1:0] K_ULF = 5'd24;
	localparam logic [KIND_W-1:0] K_ULB = 5'd25;

	// per-axis move: the axis column read as a number steps by one
	typedef enum logic [1:0] {
		MV_NONE = 2'b00,
		MV_INC  = 2'b01,
		MV_DEC  = 2'b10
	} move_t;

	typedef move_t [AXES-1:0] moves_t;

	typedef struct packed {
		logic [PATH_W-1:0]  origin_path;
		logic [DEPTH_W-1:0] path_depth;
		logic [GROUP_W-1:0] neighborhood;
	} req_item_t;

	typedef struct packed {
		logic [PATH_W-1:0] neighbor_path;
		logic [KIND_W-1:0] neighbor_kind;
		logic              found;
		logic              last;
	} rsp_item_t;

	// group a direction set belongs to
	function automatic logic [GROUP_W-1:0] kind_group(input logic [KIND_W-1:0] kind);
		logic [GROUP_W-1:0] g;
		if (kind < K_DR) begin
			g = GRP_FACE;
		end else if (kind < K_DRF) begin
			g = GRP_EDGE;
		end else begin
			g = GRP_VERTEX;
		end
		return g;
	endfunction

	// down: y-1, up: y+1, right: x+1, left: x-1, back: z-1, front: z+1
	function automatic moves_t kind_moves(input logic [KIND_W-1:0] kind);
		moves_t m;
		m[AX_X] = MV_NONE;
		m[AX_Y] = MV_NONE;
		m[AX_Z] = MV_NONE;
		case (kind)
			K_D: m[AX_Y] = MV_DEC;
			K_U: m[AX_Y] = MV_INC;
			K_R: m[AX_X] = MV_INC;
			K_L: m[AX_X] = MV_DEC;
			K_B: m[AX_Z] = MV_DEC;
			K_F: m[AX_Z] = MV_INC;
			K_DR: begin m[AX_Y] = MV_DEC; m[AX_X] = MV_INC; end
			K_DL: begin m[AX_Y] = MV_DEC; m[AX_X] = MV_DEC; end
			K_DF: begin m[AX_Y] = MV_DEC; m[AX_Z] = MV_INC; end
			K_DB: begin m[AX_Y] = MV_DEC; m[AX_Z] = MV_DEC; end
			K_UR: begin m[AX_Y] = MV_INC; m[AX_X] = MV_INC; end
			K_UL: begin m[AX_Y] = MV_INC; m[AX_X] = MV_DEC; end
			K_UF: begin m[AX_Y] = MV_INC; m[AX_Z] = MV_INC; end
			K_UB: begin m[AX_Y] = MV_INC; m[AX_Z] = MV_DEC; end
			K_BR: begin m[AX_Z] = MV_DEC; m[AX_X] = MV_INC; end
			K_BL: begin m[AX_Z] = MV_DEC; m[AX_X] = MV_DEC; end
			K_FR: begin m[AX_Z] = MV_INC; m[AX_X] = MV_INC; end
			K_FL: begin m[AX_Z] = MV_INC; m[AX_X] = MV_DEC; end
			K_DRF: begin m[AX_Y] = MV_DEC; m[AX_X] = MV_INC; m[AX_Z] = MV_INC; end
			K_DRB: begin m[AX_Y] = MV_DEC; m[AX_X] = MV_INC; m[AX_Z] = MV_DEC; end
			K_DLF: begin m[AX_Y] = MV_DEC; m[AX_X] = MV_DEC; m[AX_Z] = MV_INC; end
			K_DLB: begin m[AX_Y] = MV_DEC; m[AX_X] = MV_DEC; m[AX_Z] = MV_DEC; end
			K_URF: begin m[AX_Y] = MV_INC; m[AX_X] = MV_INC; m[AX_Z] = MV_INC; end
			K_URB: begin m[AX_Y] = MV_INC; m[AX_X] = MV_INC; m[AX_Z] = MV_DEC; end
			K_ULF: begin m[AX_Y] = MV_INC; m[AX_X] = MV_DEC; m[AX_Z] = MV_INC; end
			K_ULB: begin m[AX_Y] = MV_INC; m[AX_X] = MV_DEC; m[AX_Z] = MV_DEC; end
			default: m[AX_X] = MV_NONE;
		endcase
		return m;
	endfunction

endpackage

/* hw/rtl/onpf_prep.sv */
module onpf_prep #(
	parameter int unsigned MAX_DEPTH = onpf_pkg::MAX_DEPTH_DEF
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       req_valid,
	output logic                                       req_ready,
	input  onpf_pkg::req_item_t                        req,
	output logic                                       dec_valid,
	input  logic                                       dec_ready,
	output logic [onpf_pkg::AXES-1:0][MAX_DEPTH-1:0]   dec_coord,
	output logic [MAX_DEPTH-1:0]                       dec_lim,
	output logic [onpf_pkg::GROUP_W-1:0]               dec_grp,
	output logic                                       dec_nz
);

	localparam int unsigned DW = $clog2(MAX_DEPTH + 1);
	localparam int unsigned EXT_W = (3 * MAX_DEPTH > onpf_pkg::PATH_W) ?
		3 * MAX_DEPTH : onpf_pkg::PATH_W;

	logic                valid_s1;
	onpf_pkg::req_item_t item_s1;
	logic                ready_s1;
	logic [DW-1:0]       depth_sat;
	logic [EXT_W-1:0]    path_ext;

	assign ready_s1 = !valid_s1 || dec_ready;
	assign req_ready = ready_s1;
	assign dec_valid = valid_s1;

	// input stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && ready_s1) begin
			item_s1 <= req;
		end
	end

	// saturate depth, build the level mask
	always_comb begin
		if (item_s1.path_depth > onpf_pkg::DEPTH_W'(MAX_DEPTH)) begin
			depth_sat = DW'(MAX_DEPTH);
		end else begin
			depth_sat = item_s1.path_depth[DW-1:0];
		end
		for (int i = 0; i < MAX_DEPTH; i++) begin
			dec_lim[i] = (i < int'(depth_sat));
		end
	end

	assign dec_nz = (depth_sat != '0);
	assign dec_grp = item_s1.neighborhood;
	assign path_ext = EXT_W'(item_s1.origin_path);

	// split the path into one column per axis, level 0 as lsb
	always_comb begin
		for (int a = 0; a < onpf_pkg::AXES; a++) begin
			for (int i = 0; i < MAX_DEPTH; i++) begin
				dec_coord[a][i] = path_ext[3 * i + a] & dec_lim[i];
			end
		end
	end

endmodule

/* hw/rtl/onpf_step.sv */
module onpf_step #(
	parameter int unsigned MAX_DEPTH = onpf_pkg::MAX_DEPTH_DEF
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       dec_valid,
	output logic                                       dec_ready,
	input  logic [onpf_pkg::AXES-1:0][MAX_DEPTH-1:0]   dec_coord,
	input  logic [MAX_DEPTH-1:0]                       dec_lim,
	input  logic [onpf_pkg::GROUP_W-1:0]               dec_grp,
	input  logic                                       dec_nz,
	output logic                                       cand_valid,
	input  logic                                       cand_ready,
	output logic [onpf_pkg::AXES-1:0][MAX_DEPTH-1:0]   cand_base,
	output logic [onpf_pkg::AXES-1:0][MAX_DEPTH-1:0]   cand_inc,
	output logic [onpf_pkg::AXES-1:0][MAX_DEPTH-1:0]   cand_dec,
	output logic [onpf_pkg::KIND_COUNT-1:0]            cand_hit
);

	logic                                     valid_s2;
	logic [onpf_pkg::AXES-1:0][MAX_DEPTH-1:0] coord_s2;
	logic [MAX_DEPTH-1:0]                     lim_s2;
	logic [onpf_pkg::GROUP_W-1:0]             grp_s2;
	logic                                     nz_s2;
	logic                                     ready_s2;
	logic [onpf_pkg::AXES-1:0]                inc_ok;
	logic [onpf_pkg::AXES-1:0]                dec_ok;

	assign ready_s2 = !valid_s2 || cand_ready;
	assign dec_ready = ready_s2;
	assign cand_valid = valid_s2;

	// decoded stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= dec_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (dec_valid && ready_s2) begin
			coord_s2 <= dec_coord;
			lim_s2 <= dec_lim;
			grp_s2 <= dec_grp;
			nz_s2 <= dec_nz;
		end
	end

	// one step along each axis; a step past either end leaves the tree
	always_comb begin
		for (int a = 0; a < onpf_pkg::AXES; a++) begin
			cand_base[a] = coord_s2[a];
			cand_inc[a] = coord_s2[a] + MAX_DEPTH'(1);
			cand_dec[a] = coord_s2[a] - MAX_DEPTH'(1);
			inc_ok[a] = (coord_s2[a] != lim_s2);
			dec_ok[a] = (coord_s2[a] != '0);
		end
	end

	// which direction sets are requested and stay inside the tree
	always_comb begin
		onpf_pkg::moves_t m;
		logic ok;
		for (int k = 0; k < onpf_pkg::KIND_COUNT; k++) begin
			m = onpf_pkg::kind_moves(onpf_pkg::KIND_W'(k));
			ok = nz_s2 && ((grp_s2 & onpf_pkg::kind_group(onpf_pkg::KIND_W'(k))) != '0);
			for (int a = 0; a < onpf_pkg::AXES; a++) begin
				case (m[a])
					onpf_pkg::MV_INC: ok = ok & inc_ok[a];
					onpf_pkg::MV_DEC: ok = ok & dec_ok[a];
					default: ok = ok;
				endcase
			end
			cand_hit[k] = ok;
		end
	end

endmodule

/* hw/rtl/onpf_emit.sv */
module onpf_emit #(
	parameter int unsigned MAX_DEPTH = onpf_pkg::MAX_DEPTH_DEF
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       cand_valid,
	output logic                                       cand_ready,
	input  logic [onpf_pkg::AXES-1:0][MAX_DEPTH-1:0]   cand_base,
	input  logic [onpf_pkg::AXES-1:0][MAX_DEPTH-1:0]   cand_inc,
	input  logic [onpf_pkg::AXES-1:0][MAX_DEPTH-1:0]   cand_dec,
	input  logic [onpf_pkg::KIND_COUNT-1:0]            cand_hit,
	output logic                                       rsp_valid,
	input  logic                                       rsp_ready,
	output onpf_pkg::rsp_item_t                        rsp
);

	localparam int unsigned EXT_W = (3 * MAX_DEPTH > onpf_pkg::PATH_W) ?
		3 * MAX_DEPTH : onpf_pkg::PATH_W;

	logic                                     valid_s3;
	logic [onpf_pkg::AXES-1:0][MAX_DEPTH-1:0] base_s3;
	logic [onpf_pkg::AXES-1:0][MAX_DEPTH-1:0] inc_s3;
	logic [onpf_pkg::AXES-1:0][MAX_DEPTH-1:0] dec_s3;
	logic [onpf_pkg::KIND_COUNT-1:0]          hit_s3;
	logic                                     rsp_valid_q;
	onpf_pkg::rsp_item_t                      rsp_q;
	logic                                     take;
	logic                                     fire;
	logic                                     ready_s3;
	logic [onpf_pkg::KIND_COUNT-1:0]          pick_oh;
	logic [onpf_pkg::KIND_COUNT-1:0]          rest;
	logic [onpf_pkg::KIND_W-1:0]              pick_kind;
	logic                                     is_last;
	logic                                     any_hit;
	onpf_pkg::moves_t                         moves;
	logic [onpf_pkg::AXES-1:0][MAX_DEPTH-1:0] nb_coord;
	logic [EXT_W-1:0]                         nb_ext;
	onpf_pkg::rsp_item_t                      nxt;

	assign take = !rsp_valid_q || rsp_ready;
	assign fire = valid_s3 && take;

	// lowest pending direction set goes next
	assign pick_oh = hit_s3 & (~hit_s3 + onpf_pkg::KIND_COUNT'(1));
	assign rest = hit_s3 & ~pick_oh;
	assign any_hit = (hit_s3 != '0);
	assign is_last = (rest == '0);

	always_comb begin
		pick_kind = '0;
		for (int k = 0; k < onpf_pkg::KIND_COUNT; k++) begin
			if (pick_oh[k]) begin
				pick_kind = onpf_pkg::KIND_W'(k);
			end
		end
	end

	assign ready_s3 = !valid_s3 || (fire && is_last);
	assign cand_ready = ready_s3;

	// pick each axis column by its move
	assign moves = onpf_pkg::kind_moves(pick_kind);

	always_comb begin
		for (int a = 0; a < onpf_pkg::AXES; a++) begin
			case (moves[a])
				onpf_pkg::MV_INC: nb_coord[a] = inc_s3[a];
				onpf_pkg::MV_DEC: nb_coord[a] = dec_s3[a];
				default: nb_coord[a] = base_s3[a];
			endcase
		end
	end

	// interleave the columns back into a packed path
	always_comb begin
		nb_ext = '0;
		for (int i = 0; i < MAX_DEPTH; i++) begin
			for (int a = 0; a < onpf_pkg::AXES; a++) begin
				nb_ext[3 * i + a] = nb_coord[a][i];
			end
		end
	end

	always_comb begin
		if (any_hit) begin
			nxt.neighbor_path = nb_ext[onpf_pkg::PATH_W-1:0];
			nxt.neighbor_kind = pick_kind;
			nxt.found = 1'b1;
			nxt.last = is_last;
		end else begin
			nxt.neighbor_path = '0;
			nxt.neighbor_kind = '0;
			nxt.found = 1'b0;
			nxt.last = 1'b1;
		end
	end

	// working item register, drained one result a cycle while the output is free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ready_s3) begin
			valid_s3 <= cand_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s3) begin
			if (cand_valid) begin
				base_s3 <= cand_base;
				inc_s3 <= cand_inc;
				dec_s3 <= cand_dec;
				hit_s3 <= cand_hit;
			end
		end else if (fire) begin
			hit_s3 <= rest;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (take) begin
			rsp_valid_q <= fire;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_q <= nxt;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

endmodule

/* hw/rtl/octree_path_neighbor_finder.sv */
// An item passes the prep, step and emit stage registers, then the output register.
// Throughput: an item holds the result stage until its last result is out; it has up to
// 26 found neighbors; the result stage emits one result a cycle if the output is free.
// Items with a single result flow at one item per cycle if the output is free.
// Reset: arst_n clears the stage valid bits and the output valid; data registers keep.
module octree_path_neighbor_finder #(
	parameter int unsigned MAX_DEPTH = onpf_pkg::MAX_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  onpf_pkg::req_item_t req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output onpf_pkg::rsp_item_t rsp
);

	logic                                     dec_valid;
	logic                                     dec_ready;
	logic [onpf_pkg::AXES-1:0][MAX_DEPTH-1:0] dec_coord;
	logic [MAX_DEPTH-1:0]                     dec_lim;
	logic [onpf_pkg::GROUP_W-1:0]             dec_grp;
	logic                                     dec_nz;
	logic                                     cand_valid;
	logic                                     cand_ready;
	logic [onpf_pkg::AXES-1:0][MAX_DEPTH-1:0] cand_base;
	logic [onpf_pkg::AXES-1:0][MAX_DEPTH-1:0] cand_inc;
	logic [onpf_pkg::AXES-1:0][MAX_DEPTH-1:0] cand_dec;
	logic [onpf_pkg::KIND_COUNT-1:0]          cand_hit;

	// stage 1: capture and split into axis columns
	onpf_prep #(.MAX_DEPTH(MAX_DEPTH)) u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.dec_valid (dec_valid),
		.dec_ready (dec_ready),
		.dec_coord (dec_coord),
		.dec_lim   (dec_lim),
		.dec_grp   (dec_grp),
		.dec_nz    (dec_nz)
	);

	// stage 2: axis steps and hit mask
	onpf_step #(.MAX_DEPTH(MAX_DEPTH)) u_step (
		.clk        (clk),
		.arst_n     (arst_n),
		.dec_valid  (dec_valid),
		.dec_ready  (dec_ready),
		.dec_coord  (dec_coord),
		.dec_lim    (dec_lim),
		.dec_grp    (dec_grp),
		.dec_nz     (dec_nz),
		.cand_valid (cand_valid),
		.cand_ready (cand_ready),
		.cand_base  (cand_base),
		.cand_inc   (cand_inc),
		.cand_dec   (cand_dec),
		.cand_hit   (cand_hit)
	);

	// stage 3: emit one result per cycle while the output is free
	onpf_emit #(.MAX_DEPTH(MAX_DEPTH)) u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.cand_valid (cand_valid),
		.cand_ready (cand_ready),
		.cand_base  (cand_base),
		.cand_inc   (cand_inc),
		.cand_dec   (cand_dec),
		.cand_hit   (cand_hit),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp)
	);

`ifndef SYNTHESIS
	// a none-found result ends its item and carries no path
	a_nf_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.found |-> rsp.last && rsp.neighbor_path == '0 &&
		rsp.neighbor_kind == '0)
		else $error("none-found result malformed");

	// a found result names a real direction set
	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.found |->
		rsp.neighbor_kind < onpf_pkg::KIND_W'(onpf_pkg::KIND_COUNT))
		else $error("neighbor kind out of range");

	// a result that waits keeps its valid and its payload
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("waiting result changed");
`endif

endmodule
